@@ rtl/jacobi_laplace_relaxation_top_macros.svh @@
// Assertion macros for the Jacobi relaxation block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef JACOBI_LAPLACE_RELAXATION_TOP_MACROS_SVH
`define JACOBI_LAPLACE_RELAXATION_TOP_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define JLR_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, ignored while in reset.
`define JLR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/jlr_pkg.sv @@
// Package for the Jacobi relaxation block: item types, kind codes, register map.
// No dependencies; used by jacobi_laplace_relaxation_top.
`default_nettype none

package jlr_pkg;

    localparam int GRID_MAX_DEFAULT = 64;
    localparam int FRAC_BITS        = 24;

    localparam int CELL_W   = 32;
    localparam int COORD_W  = 6;
    localparam int SIDE_W   = 7;
    localparam int LIMIT_W  = 16;
    localparam int CHANGE_W = 31;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [SIDE_W-1:0]   GRID_SIDE_RESET   = 7'd64;
    localparam logic [LIMIT_W-1:0]  SWEEP_LIMIT_RESET = 16'd3000;
    localparam logic [CHANGE_W-1:0] THRESHOLD_RESET   = 31'd168;

    localparam logic [CHANGE_W-1:0] CHANGE_MAX = {CHANGE_W{1'b1}};

    // 100.0 in fixed point, clipped to the largest positive cell
    localparam logic [63:0]       HOT_RAW   = 64'd100 << FRAC_BITS;
    localparam logic [CELL_W-1:0] HOT_VALUE =
        (HOT_RAW > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : HOT_RAW[CELL_W-1:0];

    // x / 10 == (x * 205) >> 11, exact for x up to 1028
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_INIT  = 2'd2,
        KIND_SOLVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_GRID_SIDE        = 2'd0,
        REG_SWEEP_LIMIT      = 2'd1,
        REG_CHANGE_THRESHOLD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t                     kind;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [CELL_W-1:0]  cell_value;
    } in_item_t;

    typedef struct packed {
        logic signed [CELL_W-1:0]  read_value;
        logic [LIMIT_W-1:0]        sweeps_done;
        logic [CHANGE_W-1:0]       last_change;
        logic                      converged;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/jacobi_laplace_relaxation_top.sv @@
// Jacobi relaxation of the 2-D Laplace equation, five-point stencil, on a grid memory.
// Depends on jlr_pkg and jacobi_laplace_relaxation_top_macros.svh.
//
//  channel   handshake                        payload
//  --------  -------------------------------  ----------------------------------
//  item in   start & !busy                    cmd    (kind, row, col, cell_value)
//  item out  done, one cycle, no back-press   result (read_value, sweeps_done,
//                                                     last_change, converged)
//  config    psel & penable & pwrite (pready  paddr[3:2] register, pwdata
//            tied high)
//
// Write and read items: busy stays low, so they stream one per cycle; the result
// follows in the cycle after acceptance (registered grid memory read).
// Initialise: one cell of the GRID_MAX*GRID_MAX grid written per cycle.
// Solve: each sweep streams rows 0 to n-2 over all n columns, then drains the pipeline,
// n the side in use; the grid memory supplies one cell of two rows a cycle.
// Reset clears control and status only; the grid is undefined until written, so
// there is no clearing pass. Results cannot be stalled by the receiver.
`default_nettype none

module jacobi_laplace_relaxation_top #(
    parameter int GRID_MAX = jlr_pkg::GRID_MAX_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // item channel
    input  wire logic                       start,
    output logic                            busy,
    input  wire jlr_pkg::in_item_t          cmd,
    output logic                            done,
    output jlr_pkg::out_item_t              result,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [jlr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jlr_pkg::PDATA_W-1:0] pwdata,
    output logic [jlr_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    import jlr_pkg::*;

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int NSIDE_W = $clog2(GRID_MAX + 1);
    localparam int CELLS  = GRID_MAX * GRID_MAX;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PROD_W = NSIDE_W + 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INIT  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(GRID_MAX) + ADDR_W'(c);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]   grid_side_reg;
    logic [LIMIT_W-1:0]  sweep_limit_reg;
    logic [CHANGE_W-1:0] threshold_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg   <= GRID_SIDE_RESET;
            sweep_limit_reg <= SWEEP_LIMIT_RESET;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_GRID_SIDE:        grid_side_reg   <= pwdata[SIDE_W-1:0];
                REG_SWEEP_LIMIT:      sweep_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_CHANGE_THRESHOLD: threshold_reg   <= pwdata[CHANGE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_GRID_SIDE:        prdata = PDATA_W'(grid_side_reg);
            REG_SWEEP_LIMIT:      prdata = PDATA_W'(sweep_limit_reg);
            REG_CHANGE_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Side in use, hot-square bounds
    // ------------------------------------------------------------------
    logic [NSIDE_W-1:0] side;
    logic [NSIDE_W-1:0] side_m1;
    logic [NSIDE_W-1:0] side_m2;
    logic               side_small;
    logic [PROD_W-1:0]  tenth_prod;
    logic [NSIDE_W-1:0] tenth;

    always_comb
    begin
        if (32'(grid_side_reg) > 32'(GRID_MAX))
            side = NSIDE_W'(GRID_MAX);
        else
            side = NSIDE_W'(grid_side_reg);
    end

    assign side_m1    = side - NSIDE_W'(1);
    assign side_m2    = side - NSIDE_W'(2);
    assign side_small = side < NSIDE_W'(3);
    assign tenth_prod = PROD_W'(side) * PROD_W'(DIV10_MUL);
    assign tenth      = NSIDE_W'(tenth_prod >> DIV10_SHIFT);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic [LIMIT_W-1:0]  solve_count_reg, solve_count_next;
    logic [LIMIT_W-1:0]  sweep_count_reg, sweep_count_next;
    logic [CHANGE_W-1:0] last_change_reg, last_change_next;
    logic                converged_reg, converged_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_read_reg, res_read_next;
    logic [NSIDE_W-1:0]  hot_lo_reg, hot_hi_reg;

    logic                accept;
    logic                cmd_inside;
    logic [ADDR_W-1:0]   cmd_addr;
    logic                issue;
    logic                sweep_begin;
    logic                pipe_busy;
    logic [32:0]         max_change_reg;
    logic [CHANGE_W-1:0] change_sat;
    logic [LIMIT_W-1:0]  count_inc;
    logic                last_col;
    logic                hot_cell;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign cmd_inside = (32'(cmd.row) < 32'(GRID_MAX)) && (32'(cmd.col) < 32'(GRID_MAX));
    assign cmd_addr   = cell_addr(IDX_W'(cmd.row), IDX_W'(cmd.col));
    assign last_col   = (NSIDE_W'(col_reg) == side_m1);
    assign count_inc  = solve_count_reg + LIMIT_W'(1);
    assign change_sat = (max_change_reg > 33'(CHANGE_MAX)) ? CHANGE_MAX
                                                           : max_change_reg[CHANGE_W-1:0];
    assign hot_cell   = (NSIDE_W'(row_reg) >= hot_lo_reg) && (NSIDE_W'(row_reg) < hot_hi_reg)
                     && (NSIDE_W'(col_reg) >= hot_lo_reg) && (NSIDE_W'(col_reg) < hot_hi_reg);

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        solve_count_next = solve_count_reg;
        sweep_count_next = sweep_count_reg;
        last_change_next = last_change_reg;
        converged_next   = converged_reg;
        res_valid_next   = 1'b0;
        res_read_next    = 1'b0;
        issue            = 1'b0;
        sweep_begin      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        KIND_WRITE:
                            res_valid_next = 1'b1;
                        KIND_READ:
                        begin
                            res_valid_next = 1'b1;
                            res_read_next  = cmd_inside;
                        end
                        KIND_INIT:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            state_next = ST_INIT;
                        end
                        KIND_SOLVE:
                        begin
                            if (sweep_limit_reg == '0)
                            begin
                                // no sweep allowed: report an empty solve
                                res_valid_next   = 1'b1;
                                sweep_count_next = '0;
                                last_change_next = '0;
                                converged_next   = 1'b0;
                            end
                            else
                            begin
                                solve_count_next = '0;
                                sweep_begin      = 1'b1;
                                row_next         = '0;
                                col_next         = '0;
                                state_next       = side_small ? ST_DRAIN : ST_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_INIT:
            begin
                if (col_reg == IDX_W'(GRID_MAX - 1))
                begin
                    col_next = '0;
                    if (row_reg == IDX_W'(GRID_MAX - 1))
                    begin
                        state_next     = ST_IDLE;
                        res_valid_next = 1'b1;
                    end
                    else
                        row_next = row_reg + IDX_W'(1);
                end
                else
                    col_next = col_reg + IDX_W'(1);
            end

            ST_SWEEP:
            begin
                issue = 1'b1;
                if (last_col)
                begin
                    col_next = '0;
                    if (NSIDE_W'(row_reg) == side_m2)
                        state_next = ST_DRAIN;
                    else
                        row_next = row_reg + IDX_W'(1);
                end
                else
                    col_next = col_reg + IDX_W'(1);
            end

            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    if ((change_sat <= threshold_reg) || (count_inc == sweep_limit_reg))
                    begin
                        sweep_count_next = count_inc;
                        last_change_next = change_sat;
                        converged_next   = (change_sat <= threshold_reg);
                        res_valid_next   = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        solve_count_next = count_inc;
                        sweep_begin      = 1'b1;
                        row_next         = '0;
                        col_next         = '0;
                        state_next       = side_small ? ST_DRAIN : ST_SWEEP;
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            solve_count_reg <= '0;
            sweep_count_reg <= '0;
            last_change_reg <= '0;
            converged_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_read_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            solve_count_reg <= solve_count_next;
            sweep_count_reg <= sweep_count_next;
            last_change_reg <= last_change_next;
            converged_reg   <= converged_next;
            res_valid_reg   <= res_valid_next;
            res_read_reg    <= res_read_next;
        end
    end

    // hot-square bounds, taken when an initialise item is accepted
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.kind == KIND_INIT))
        begin
            hot_lo_reg <= side >> 1;
            hot_hi_reg <= (side >> 1) + tenth;
        end
    end

    // ------------------------------------------------------------------
    // Grid memory: two read ports, one write port, registered read data
    // ------------------------------------------------------------------
    logic signed [CELL_W-1:0] grid_mem [CELLS];
    logic signed [CELL_W-1:0] grid_qa_reg, grid_qb_reg;
    logic                     grid_we;
    logic [ADDR_W-1:0]        grid_waddr;
    logic signed [CELL_W-1:0] grid_wdata;
    logic [ADDR_W-1:0]        grid_raddr_a, grid_raddr_b;

    // row above, old values, for the row being relaxed
    logic signed [CELL_W-1:0] above_mem [GRID_MAX];
    logic signed [CELL_W-1:0] above_q_reg;

    // relaxation pipeline
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [IDX_W-1:0]         s1_row_reg, s1_col_reg;
    logic                     s1_compute;
    logic signed [CELL_W-1:0] cur_m1_reg, cur_m2_reg, above_m1_reg, below_m1_reg;
    logic signed [32:0]       s2_sum_a_reg, s2_sum_b_reg;
    logic signed [CELL_W-1:0] s2_old_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic signed [33:0]       sum_all;
    logic signed [CELL_W-1:0] s3_new_reg, s3_old_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;
    logic signed [32:0]       diff_pos, diff_neg;
    logic [32:0]              s4_mag_reg;

    assign grid_raddr_a = (state_reg == ST_SWEEP) ? cell_addr(row_reg, col_reg) : cmd_addr;
    assign grid_raddr_b = cell_addr(row_reg + IDX_W'(1), col_reg);

    always_comb
    begin
        grid_we    = 1'b0;
        grid_waddr = cmd_addr;
        grid_wdata = cmd.cell_value;
        if (s3_valid_reg)
        begin
            grid_we    = 1'b1;
            grid_waddr = s3_addr_reg;
            grid_wdata = s3_new_reg;
        end
        else if (state_reg == ST_INIT)
        begin
            grid_we    = 1'b1;
            grid_waddr = cell_addr(row_reg, col_reg);
            grid_wdata = hot_cell ? HOT_VALUE : '0;
        end
        else if (accept && (cmd.kind == KIND_WRITE) && cmd_inside)
            grid_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        grid_qa_reg <= grid_mem[grid_raddr_a];
        grid_qb_reg <= grid_mem[grid_raddr_b];
    end

    // stage 1 stores the old cell of the current row for the next row's use
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            above_mem[s1_col_reg] <= grid_qa_reg;
        above_q_reg <= above_mem[col_reg];
    end

    // interior columns only, and not on the pre-load pass over row 0
    assign s1_compute = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg >= IDX_W'(2));
    assign pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            max_change_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_compute;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (sweep_begin)
                max_change_reg <= '0;
            else if (s4_valid_reg && (s4_mag_reg > max_change_reg))
                max_change_reg <= s4_mag_reg;
        end
    end

    assign sum_all  = {s2_sum_a_reg[32], s2_sum_a_reg} + {s2_sum_b_reg[32], s2_sum_b_reg};
    assign diff_pos = {s3_new_reg[CELL_W-1], s3_new_reg} - {s3_old_reg[CELL_W-1], s3_old_reg};
    assign diff_neg = {s3_old_reg[CELL_W-1], s3_old_reg} - {s3_new_reg[CELL_W-1], s3_new_reg};

    always_ff @(posedge clk)
    begin
        s1_row_reg <= row_reg;
        s1_col_reg <= col_reg;

        // sliding window over the current row, plus above/below of the centre column
        if (s1_valid_reg)
        begin
            cur_m1_reg   <= grid_qa_reg;
            cur_m2_reg   <= cur_m1_reg;
            above_m1_reg <= above_q_reg;
            below_m1_reg <= grid_qb_reg;
        end

        s2_sum_a_reg <= {cur_m2_reg[CELL_W-1], cur_m2_reg} + {grid_qa_reg[CELL_W-1], grid_qa_reg};
        s2_sum_b_reg <= {above_m1_reg[CELL_W-1], above_m1_reg}
                      + {below_m1_reg[CELL_W-1], below_m1_reg};
        s2_old_reg   <= cur_m1_reg;
        s2_addr_reg  <= cell_addr(s1_row_reg, s1_col_reg - IDX_W'(1));

        // quarter sum, floor; always fits in a cell
        s3_new_reg  <= sum_all[33:2];
        s3_old_reg  <= s2_old_reg;
        s3_addr_reg <= s2_addr_reg;

        s4_mag_reg <= diff_pos[32] ? diff_neg : diff_pos;
    end

    // ------------------------------------------------------------------
    // Result item
    // ------------------------------------------------------------------
    assign done               = res_valid_reg;
    assign result.read_value  = res_read_reg ? grid_qa_reg : '0;
    assign result.sweeps_done = sweep_count_reg;
    assign result.last_change = last_change_reg;
    assign result.converged   = converged_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "jacobi_laplace_relaxation_top_macros.svh"

    `JLR_ASSERT_IMPL(a_idle_pipe_empty, !busy, !pipe_busy)
    `JLR_ASSERT_NEXT(a_access_result,
        start && !busy && (cmd.kind == KIND_WRITE || cmd.kind == KIND_READ), done)
    `JLR_ASSERT_IMPL(a_conv_needs_sweep, sweep_count_reg == '0, !converged_reg)
    `JLR_ASSERT_IMPL(a_writeback_in_solve, s3_valid_reg,
        state_reg == ST_SWEEP || state_reg == ST_DRAIN)

endmodule

`default_nettype wire
